[src/cfr_pkg.sv]
// Shared types and constants of the checksummed frame receiver.
package cfr_pkg;

   localparam int BYTE_W  = 8;
   localparam int POS_W   = 8;
   localparam int EVENT_W = 3;
   localparam int CMD_W   = 16;
   localparam int ERR_W   = 32;
   localparam int HEAD_W  = 48;
   localparam int COUNT_W = 8;

   // Result codes.
   typedef enum logic [EVENT_W-1:0] {
      EV_OK       = 3'd0,
      EV_DATA_SUM = 3'd1,
      EV_RESET    = 3'd2,
      EV_HEADER   = 3'd3,
      EV_LENGTH   = 3'd4,
      EV_HEAD_SUM = 3'd5
   } event_type;

   // Fixed frame header.
   localparam int MARK_LEN = 8;
   localparam logic [BYTE_W-1:0] FRAME_MARK [MARK_LEN] =
      '{8'hF1, 8'h1F, 8'hE2, 8'h2E, 8'hB6, 8'h6B, 8'hA8, 8'h8A};

   localparam logic [BYTE_W-1:0] RESET_BYTE = 8'h55;

   // Frame byte positions.
   localparam logic [POS_W-1:0] LEN_HI_POS    = 8'd8;
   localparam logic [POS_W-1:0] LEN_LO_POS    = 8'd9;
   localparam logic [POS_W-1:0] HEAD_SUM_POS  = 8'd10;
   localparam logic [POS_W-1:0] DATA_POS      = 8'd11;
   localparam logic [POS_W-1:0] CMD_HI_POS    = 8'd15;
   localparam logic [POS_W-1:0] CMD_LO_POS    = 8'd16;
   localparam int               ERR_FIRST_POS = 17;
   localparam int               ERR_BYTES     = 4;
   localparam int               PAY_FIRST_POS = 21;

   // Length limits: total = length + LEN_ADD, kept only in MIN_TOTAL+1 .. 255.
   localparam logic [8:0] LEN_ADD    = 9'd11;
   localparam logic [8:0] MIN_TOTAL  = 9'd17;
   localparam logic [POS_W-1:0] COUNT_BASE = 8'd22;

   typedef struct packed {
      event_type           event_res;
      logic [CMD_W-1:0]    command_code;
      logic [ERR_W-1:0]    error_word;
      logic [HEAD_W-1:0]   payload_head;
      logic [COUNT_W-1:0]  payload_count;
   } rsp_type;

endpackage

[src/cfr_req_if.sv]
// Request channel: one received byte per transfer.
interface cfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/cfr_rsp_if.sv]
// Response channel: one frame result per transfer.
interface cfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [15:0] command_code;
   logic [31:0] error_word;
   logic [47:0] payload_head;
   logic [7:0]  payload_count;

   modport source (output valid, output event_res, output command_code, output error_word,
                   output payload_head, output payload_count, input ready);
   modport sink   (input valid, input event_res, input command_code, input error_word,
                   input payload_head, input payload_count, output ready);
endinterface

[src/checksummed_frame_receiver.sv]
// Top level of the checksummed frame receiver: byte deframer with result buffering.
//
//   channel   dir   payload                                          handshake
//   req_ch    in    rx_byte[7:0]                                     valid/ready
//   rsp_ch    out   event_res, command_code, error_word,             valid/ready
//                   payload_head, payload_count
//
// One byte per cycle while the skid register is empty: each request is checked
// and folded into the frame state in the cycle it is accepted, by one compare and
// one 8-bit add. A result is registered in the output register as the byte that
// ends the frame is accepted; a second result waits in a skid register while the
// output stalls. req_ch.ready drops only while the skid register is full.
// Synchronous active-high reset clears the frame state and both result slots.
module checksummed_frame_receiver #(
   parameter int PAYLOAD_KEEP = 6
) (
   input  logic      clock,
   input  logic      reset,
   cfr_req_if.sink   req_ch,
   cfr_rsp_if.source rsp_ch
);
   import cfr_pkg::*;

   localparam int PAY_W = 8 * PAYLOAD_KEEP;

   // Frame state.
   logic [POS_W-1:0]  pos_ff,   pos_in;
   logic [POS_W-1:0]  total_ff, total_in;
   logic [BYTE_W-1:0] len_hi_ff, len_hi_in;
   logic [BYTE_W-1:0] sum_ff,   sum_in;
   logic [CMD_W-1:0]  cmd_ff,   cmd_in;
   logic [ERR_W-1:0]  err_ff,   err_in;
   logic [PAY_W-1:0]  pay_ff,   pay_in;

   // Result slots.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff,       out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff,       skid_in;

   logic [BYTE_W-1:0] rx;
   logic              accept;
   logic              emit;
   event_type         ev;
   logic [8:0]        total_calc;
   logic [BYTE_W-1:0] sum_next;
   logic              in_data;
   rsp_type           result;
   logic [63:0]       pay_ext;

   assign rx       = req_ch.rx_byte;
   assign accept   = req_ch.valid && req_ch.ready;
   assign sum_next = sum_ff + rx;
   assign total_calc = {1'b0, rx} + LEN_ADD;
   // Data byte while the checksum byte is still ahead.
   assign in_data  = ({1'b0, pos_ff} + 9'd1) < {1'b0, total_ff};

   // Advance the frame on each accepted byte; every result restarts the frame.
   always_comb begin
      pos_in    = pos_ff;
      total_in  = total_ff;
      len_hi_in = len_hi_ff;
      sum_in    = sum_ff;
      cmd_in    = cmd_ff;
      err_in    = err_ff;
      pay_in    = pay_ff;
      emit      = 1'b0;
      ev        = EV_OK;
      if (accept) begin
         if (pos_ff < POS_W'(MARK_LEN)) begin
            if (pos_ff == '0 && rx == RESET_BYTE) begin
               emit = 1'b1;
               ev   = EV_RESET;
            end else if (rx != FRAME_MARK[pos_ff[2:0]]) begin
               emit = 1'b1;
               ev   = EV_HEADER;
            end else begin
               sum_in = sum_next;
               pos_in = pos_ff + 8'd1;
            end
         end else if (pos_ff == LEN_HI_POS) begin
            len_hi_in = rx;
            sum_in    = sum_next;
            pos_in    = LEN_LO_POS;
         end else if (pos_ff == LEN_LO_POS) begin
            if (len_hi_ff != '0 || total_calc <= MIN_TOTAL || total_calc[8]) begin
               emit = 1'b1;
               ev   = EV_LENGTH;
            end else begin
               total_in = total_calc[7:0];
               sum_in   = sum_next;
               pos_in   = HEAD_SUM_POS;
            end
         end else if (pos_ff == HEAD_SUM_POS) begin
            if (sum_next != '0) begin
               emit = 1'b1;
               ev   = EV_HEAD_SUM;
            end else begin
               sum_in = '0;
               pos_in = DATA_POS;
            end
         end else if (in_data) begin
            // Capture the fixed fields and the head of the payload.
            if (pos_ff == CMD_HI_POS) cmd_in[15:8] = rx;
            if (pos_ff == CMD_LO_POS) cmd_in[7:0]  = rx;
            for (int k = 0; k < ERR_BYTES; k++) begin
               if (pos_ff == POS_W'(ERR_FIRST_POS + k))
                  err_in[(ERR_BYTES-1-k)*8 +: 8] = rx;
            end
            for (int k = 0; k < PAYLOAD_KEEP; k++) begin
               if (pos_ff == POS_W'(PAY_FIRST_POS + k))
                  pay_in[(PAYLOAD_KEEP-1-k)*8 +: 8] = rx;
            end
            sum_in = sum_next;
            pos_in = pos_ff + 8'd1;
         end else begin
            emit = 1'b1;
            ev   = (sum_next != '0) ? EV_DATA_SUM : EV_OK;
         end
         if (emit) begin
            pos_in    = '0;
            total_in  = '0;
            len_hi_in = '0;
            sum_in    = '0;
            cmd_in    = '0;
            err_in    = '0;
            pay_in    = '0;
         end
      end
   end

   // Build the result; error results carry zero fields.
   assign pay_ext = 64'(pay_ff);
   always_comb begin
      result           = '0;
      result.event_res = ev;
      if (ev == EV_OK) begin
         result.command_code  = cmd_ff;
         result.error_word    = err_ff;
         result.payload_head  = pay_ext[HEAD_W-1:0];
         result.payload_count = (total_ff > COUNT_BASE) ? (total_ff - COUNT_BASE) : '0;
      end
   end

   // Output register with skid slot: drain skid first, else load the new result.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_ch.ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (emit) begin
            out_valid_in = 1'b1;
            out_in       = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (emit) begin
         // Hold the new result while the output stalls.
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         total_ff      <= '0;
         len_hi_ff     <= '0;
         sum_ff        <= '0;
         cmd_ff        <= '0;
         err_ff        <= '0;
         pay_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         total_ff      <= total_in;
         len_hi_ff     <= len_hi_in;
         sum_ff        <= sum_in;
         cmd_ff        <= cmd_in;
         err_ff        <= err_in;
         pay_ff        <= pay_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_ch.ready         = !skid_valid_ff;
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.event_res     = out_ff.event_res;
   assign rsp_ch.command_code  = out_ff.command_code;
   assign rsp_ch.error_word    = out_ff.error_word;
   assign rsp_ch.payload_head  = out_ff.payload_head;
   assign rsp_ch.payload_count = out_ff.payload_count;

   // The skid slot fills only behind a stalled output.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid slot holds a result while the output is empty");

   // Once in the data part, the position stays below the frame total.
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (pos_ff >= DATA_POS) |-> (pos_ff < total_ff))
      else $error("byte position ran past the frame total");

   // A reset byte at frame start always produces a result.
   a_reset_byte: assert property (@(posedge clock) disable iff (reset)
      (accept && pos_ff == '0 && rx == RESET_BYTE) |=> out_valid_ff)
      else $error("reset byte at frame start gave no result");

   // Error results carry zero fields.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.event_res != EV_OK) |->
      (out_ff.command_code == '0 && out_ff.error_word == '0 &&
       out_ff.payload_head == '0 && out_ff.payload_count == '0))
      else $error("error result with nonzero fields");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the checksummed frame receiver with directed and random byte streams.
module testbench;
   import cfr_pkg::*;

   localparam int PAYLOAD_KEEP = 6;
   // Cycles without any accepted request or result before the run is declared hung.
   localparam int IDLE_LIMIT   = 2000;
   // Settle time after the last result, well past the output and skid register latency.
   localparam int DRAIN_CYCLES = 16;

   // Frame constants, kept independent of the package so a wrong package value shows up.
   localparam logic [7:0] SYNC_MARK [8] =
      '{8'hF1, 8'h1F, 8'hE2, 8'h2E, 8'hB6, 8'h6B, 8'hA8, 8'h8A};
   localparam logic [7:0] RESET_FLAG_BYTE = 8'h55;

   localparam rsp_type NO_RSP     = '0;
   localparam rsp_type RESET_RSP  = '{EV_RESET, 16'h0, 32'h0, 48'h0, 8'h0};
   localparam rsp_type HEADER_RSP = '{EV_HEADER, 16'h0, 32'h0, 48'h0, 8'h0};

   typedef struct {
      logic [7:0] rx_byte;
      bit         typed;   // expected result written out in the row
      rsp_type    want;
   } stim_row;

   logic clock;
   logic reset;

   cfr_req_if req_ch ();
   cfr_rsp_if rsp_ch ();

   checksummed_frame_receiver #(
      .PAYLOAD_KEEP (PAYLOAD_KEEP)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Deframer state mirrored by the predictor.
   logic [7:0]  pos_q;
   logic [7:0]  total_q;
   logic [7:0]  len_hi_q;
   logic [7:0]  sum_q;
   logic [15:0] cmd_q;
   logic [31:0] err_q;
   logic [63:0] pay_q;

   rsp_type frame_results_due [$];
   int      mismatch_count = 0;
   int      items_sent     = 0;
   int      idle_cycles    = 0;

   // Sender burst shaping.
   int burst_left = 0;
   int gap_left   = 0;

   // Receiver stall pattern.
   int stall_mode  = 0;
   int stall_left  = 0;
   int stall_phase = 0;

   // Directed stream: reset flag, header mismatches at both byte extremes, an offending
   // byte that must be consumed rather than taken as a new frame start, then the shortest
   // legal frame with 00 and FF data bytes.
   stim_row directed_rows [23] = '{
      '{8'h55, 1'b1, RESET_RSP},
      '{8'h00, 1'b1, HEADER_RSP},
      '{8'hFF, 1'b1, HEADER_RSP},
      '{8'hF1, 1'b0, NO_RSP},
      '{8'hF1, 1'b1, HEADER_RSP},
      '{8'hF1, 1'b0, NO_RSP},
      '{8'h1F, 1'b0, NO_RSP},
      '{8'hE2, 1'b0, NO_RSP},
      '{8'h2E, 1'b0, NO_RSP},
      '{8'hB6, 1'b0, NO_RSP},
      '{8'h6B, 1'b0, NO_RSP},
      '{8'hA8, 1'b0, NO_RSP},
      '{8'h8A, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP},
      '{8'h07, 1'b0, NO_RSP},
      '{8'h86, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, NO_RSP},
      '{8'h12, 1'b0, NO_RSP},
      '{8'h34, 1'b0, NO_RSP},
      '{8'hAB, 1'b0, NO_RSP},
      '{8'hCD, 1'b0, NO_RSP},
      '{8'h43, 1'b0, NO_RSP}
   };

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Advance the deframer by one byte; return 1 and fill the result when the byte ends a frame.
   function automatic bit deframe_byte(input logic [7:0] b, output rsp_type r);
      logic [16:0] full_len;
      logic [7:0]  folded;
      event_type   ev;
      bit          done;
      int          slot;
      r        = '0;
      ev       = EV_OK;
      done     = 1'b0;
      folded   = sum_q + b;
      full_len = {1'b0, len_hi_q, b} + 17'd11;
      slot     = int'(pos_q) - 21;
      if (pos_q < 8) begin
         if (pos_q == 0 && b == RESET_FLAG_BYTE) begin
            ev   = EV_RESET;
            done = 1'b1;
         end else if (b != SYNC_MARK[pos_q[2:0]]) begin
            ev   = EV_HEADER;
            done = 1'b1;
         end else begin
            sum_q = folded;
            pos_q = pos_q + 8'd1;
         end
      end else if (pos_q == 8) begin
         len_hi_q = b;
         sum_q    = folded;
         pos_q    = 8'd9;
      end else if (pos_q == 9) begin
         if (full_len <= 17 || full_len >= 256) begin
            ev   = EV_LENGTH;
            done = 1'b1;
         end else begin
            total_q = full_len[7:0];
            sum_q   = folded;
            pos_q   = 8'd10;
         end
      end else if (pos_q == 10) begin
         if (folded != 8'h00) begin
            ev   = EV_HEAD_SUM;
            done = 1'b1;
         end else begin
            sum_q = 8'h00;
            pos_q = 8'd11;
         end
      end else if (int'(pos_q) + 1 < int'(total_q)) begin
         // Capture command, error word and the leading payload bytes on the way.
         if (pos_q == 15)
            cmd_q[15:8] = b;
         else if (pos_q == 16)
            cmd_q[7:0] = b;
         else if (pos_q >= 17 && pos_q <= 20)
            err_q = err_q | (32'(b) << ((20 - int'(pos_q)) * 8));
         else if (slot >= 0 && slot < PAYLOAD_KEEP)
            pay_q = pay_q | (64'(b) << (((PAYLOAD_KEEP - 1 - slot) & 7) * 8));
         sum_q = folded;
         pos_q = pos_q + 8'd1;
      end else begin
         ev   = (folded != 8'h00) ? EV_DATA_SUM : EV_OK;
         done = 1'b1;
      end
      if (done) begin
         r.event_res = ev;
         if (ev == EV_OK) begin
            r.command_code  = cmd_q;
            r.error_word    = err_q;
            r.payload_head  = pay_q[47:0];
            r.payload_count = (total_q > 8'd22) ? total_q - 8'd22 : 8'd0;
         end
         // Every result ends the frame: restart at frame start.
         pos_q    = '0;
         total_q  = '0;
         len_hi_q = '0;
         sum_q    = '0;
         cmd_q    = '0;
         err_q    = '0;
         pay_q    = '0;
      end
      return done;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 50)
         $display("%0t MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Send one request in burst/gap rhythm, then queue what it should produce.
   // Entered and left at a falling edge.
   task automatic feed_byte(input logic [7:0] b, input bit typed, input rsp_type want);
      rsp_type predicted;
      bit      has_rsp;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap_left) @(negedge clock);
         gap_left = 0;
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      @(negedge clock);
      has_rsp = deframe_byte(b, predicted);
      if (typed)
         frame_results_due = {frame_results_due, want};
      else if (has_rsp)
         frame_results_due = {frame_results_due, predicted};
   endtask

   // Receiver: pick a new random stall behavior whenever the current one runs out.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_left  = $urandom_range(20, 80);
         stall_phase = 0;
      end else begin
         stall_left--;
         stall_phase++;
      end
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         2:       rsp_ch.ready <= (stall_phase % 4 == 0);
         default: rsp_ch.ready <= (stall_phase % 12 >= 9);
      endcase
   end

   // Result checker and hang watchdog.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_results_due.size() == 0) begin
               report_mismatch("result with none pending, event", 64'(rsp_ch.event_res),
                               '0);
            end else begin
               want = frame_results_due.pop_front();
               if (rsp_ch.event_res != want.event_res)
                  report_mismatch("event_res", 64'(rsp_ch.event_res), 64'(want.event_res));
               if (rsp_ch.command_code != want.command_code)
                  report_mismatch("command_code", 64'(rsp_ch.command_code),
                                  64'(want.command_code));
               if (rsp_ch.error_word != want.error_word)
                  report_mismatch("error_word", 64'(rsp_ch.error_word),
                                  64'(want.error_word));
               if (rsp_ch.payload_head != want.payload_head)
                  report_mismatch("payload_head", 64'(rsp_ch.payload_head),
                                  64'(want.payload_head));
               if (rsp_ch.payload_count != want.payload_count)
                  report_mismatch("payload_count", 64'(rsp_ch.payload_count),
                                  64'(want.payload_count));
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  frame_bytes [$];
      logic [15:0] len_field;
      logic [7:0]  acc;
      logic [7:0]  data;
      logic [7:0]  flip;
      int          kind;
      int          frame_len;
      int          cut;
      int          frames_built;
      bit          paused_once;

      frames_built   = 0;
      paused_once    = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      pos_q          = '0;
      total_q        = '0;
      len_hi_q       = '0;
      sum_q          = '0;
      cmd_q          = '0;
      err_q          = '0;
      pay_q          = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         feed_byte(directed_rows[i].rx_byte, directed_rows[i].typed, directed_rows[i].want);

      // Random part: mostly well-formed frames with random content, plus frames broken
      // at one point (header, length, header checksum, data checksum) and loose noise.
      while (items_sent < 550) begin
         frame_bytes.delete();
         kind = $urandom_range(0, 19);
         if (kind >= 18) begin
            if (kind == 19)
               frame_bytes = {frame_bytes, RESET_FLAG_BYTE};
            repeat ($urandom_range(1, 4)) frame_bytes = {frame_bytes, 8'($urandom)};
         end else begin
            // Keep most frames short; only a few reach the longest legal total.
            frame_len = ($urandom_range(0, 23) == 0) ? $urandom_range(18, 255)
                                                     : $urandom_range(18, 34);
            len_field = 16'(frame_len - 11);
            acc = 8'h00;
            for (int i = 0; i < 8; i++) begin
               frame_bytes = {frame_bytes, SYNC_MARK[i]};
               acc = acc + SYNC_MARK[i];
            end
            frame_bytes = {frame_bytes, len_field[15:8]};
            frame_bytes = {frame_bytes, len_field[7:0]};
            acc = acc + len_field[15:8] + len_field[7:0];
            frame_bytes = {frame_bytes, 8'(0 - acc)};
            acc = 8'h00;
            for (int i = 11; i < frame_len - 1; i++) begin
               data = 8'($urandom);
               frame_bytes = {frame_bytes, data};
               acc = acc + data;
            end
            frame_bytes = {frame_bytes, 8'(0 - acc)};
            flip = 8'($urandom_range(1, 255));
            cut  = frame_bytes.size();
            case (kind)
               12, 13: begin
                  cut = $urandom_range(0, 7);
                  frame_bytes[cut] = frame_bytes[cut] ^ flip;
                  cut = cut + 1;
               end
               14: begin
                  case ($urandom_range(0, 3))
                     0:       len_field = 16'($urandom_range(0, 6));
                     1:       len_field = 16'($urandom_range(245, 255));
                     2:       len_field = 16'($urandom_range(256, 65535));
                     default: len_field = 16'hFFFF;
                  endcase
                  frame_bytes[8] = len_field[15:8];
                  frame_bytes[9] = len_field[7:0];
                  cut = 10;
               end
               15: begin
                  frame_bytes[10] = frame_bytes[10] ^ flip;
                  cut = 11;
               end
               16, 17: frame_bytes[frame_bytes.size() - 1] =
                          frame_bytes[frame_bytes.size() - 1] ^ flip;
               default: ;
            endcase
            // Drop everything past the offending byte.
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end
         foreach (frame_bytes[i])
            feed_byte(frame_bytes[i], 1'b0, NO_RSP);
         frames_built++;

         // Hold the sender until the receiver has drained every pending result.
         if ((frames_built % 17 == 9 || !paused_once) && frame_results_due.size() != 0) begin
            paused_once = 1'b1;
            req_ch.valid <= 1'b0;
            while (frame_results_due.size() != 0) @(negedge clock);
         end
      end

      req_ch.valid <= 1'b0;
      while (frame_results_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
